[design/bdpi_pkg.sv]
// Shared constants, codes and types for the bellows drive PI controller.
// Used by the top level and by the serial divider; depends on nothing.

package bdpi_pkg;

  // control periods per second, sets the velocity scale
  localparam int PERIODS_PER_SECOND = 20;

  // stream and configuration widths
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 72;
  localparam int OP_W        = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // operation codes carried in the input tuser
  localparam logic [OP_W-1:0] OP_START_VOL = 3'd0;
  localparam logic [OP_W-1:0] OP_START_PRS = 3'd1;
  localparam logic [OP_W-1:0] OP_START_EXH = 3'd2;
  localparam logic [OP_W-1:0] OP_TICK_VOL  = 3'd3;
  localparam logic [OP_W-1:0] OP_TICK_PRS  = 3'd4;
  localparam logic [OP_W-1:0] OP_TICK_EXH  = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BAG_CONTACT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_STOP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEAN_FLOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXH_VEL     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INH_PERIODS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PRS_LIMIT   = 3'd5;

  // shared multiplier geometry
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 19;
  localparam int ACC_W   = 48;

  // Q16.16 gains and filter weights, as multiplier B operands
  localparam logic signed [MUL_B_W-1:0] KP_INH      = 19'sd4588;
  localparam logic signed [MUL_B_W-1:0] KP_EXH      = 19'sd5243;
  localparam logic signed [MUL_B_W-1:0] K_SMALL     = 19'sd66;
  localparam logic signed [MUL_B_W-1:0] KI_EXH      = 19'sd7;
  localparam logic signed [MUL_B_W-1:0] KI_PRS      = 19'sd6554;
  localparam logic signed [MUL_B_W-1:0] KP_PRS      = 19'sd131072;
  localparam logic signed [MUL_B_W-1:0] RAMP_SLOPE2 = 19'sd144180;
  localparam logic signed [MUL_B_W-1:0] FILT_OLD    = 19'sd39322;
  localparam logic signed [MUL_B_W-1:0] FILT_NEW    = 19'sd26214;
  localparam logic signed [MUL_B_W-1:0] FLOW_K_NEAR = 19'sd8;
  localparam logic signed [MUL_B_W-1:0] FLOW_K_FAR  = 19'sd12;
  // target / 8 and target / 12, both as (target * k) >> 19
  localparam logic signed [MUL_B_W-1:0] RECIP_8     = 19'sd65536;
  localparam logic signed [MUL_B_W-1:0] RECIP_12    = 19'sd43691;

  // ramp factor terms
  localparam int             RAMP_W    = 17;
  localparam logic [RAMP_W-1:0] RAMP_BASE = 17'd13107;
  localparam logic [RAMP_W-1:0] FLOW_HIGH = 17'd85197;

  // start duties and exhale clamp
  localparam logic [7:0] DUTY_START_VOL = 8'd60;
  localparam logic [7:0] DUTY_START_PRS = 8'd80;
  localparam logic [7:0] DUTY_START_EXH = 8'd18;
  localparam logic [7:0] DUTY_MIN       = 8'd0;
  localparam logic [7:0] DUTY_MAX       = 8'd255;
  localparam logic [7:0] DUTY_EXH_MIN   = 8'd35;
  localparam logic [7:0] DUTY_EXH_MAX   = 8'd40;

  // serial divider geometry: ramp numerator over inhale periods
  localparam int DIV_DVD_W = 27;
  localparam int DIV_DVS_W = 10;

  typedef struct packed {
    logic                 start;
    logic [DIV_DVD_W-1:0] dividend;
    logic [DIV_DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

[design/bdpi_div.sv]
// Restoring serial divider, one quotient bit per cycle.
// Depends on bdpi_pkg for widths and the request/response types.

module bdpi_div (
  input  logic               clk,
  input  logic               rst,
  input  bdpi_pkg::div_req_t req,
  output bdpi_pkg::div_rsp_t rsp
);
  import bdpi_pkg::*;

  localparam int CNT_W = $clog2(DIV_DVD_W + 1);

  logic [DIV_DVD_W-1:0] dvd;
  logic [DIV_DVS_W-1:0] dvs;
  logic [DIV_DVS_W-1:0] rem;
  logic [CNT_W-1:0]     cnt;
  logic                 done;
  logic [DIV_DVS_W:0]   rem_sh;
  logic [DIV_DVS_W:0]   rem_sub;
  logic                 fits;

  // trial subtract of the divisor from the shifted remainder
  always_comb begin
    rem_sh  = {rem, dvd[DIV_DVD_W-1]};
    fits    = (rem_sh >= {1'b0, dvs});
    rem_sub = rem_sh - {1'b0, dvs};
  end

  // count iterations and flag completion
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        cnt <= CNT_W'(DIV_DVD_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // shift quotient bits into the dividend register
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dvs <= req.divisor;
      rem <= '0;
    end else if (cnt != '0) begin
      rem <= fits ? rem_sub[DIV_DVS_W-1:0] : rem_sh[DIV_DVS_W-1:0];
      dvd <= {dvd[DIV_DVD_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = dvd;

endmodule

[design/bellows_drive_pi_controller.sv]
// Bellows drive PI controller: one item per control period, one result per item.
// Phase starts take the shortest path, pressure and exhale ticks add their error steps, and
// volume ticks take the longest path, longer still while the target flow ramps through the serial divider.
// One item at a time: a shared 32x19 multiplier and one accumulator are stepped by a sequencer.
// The next item can be accepted in the cycle after the result is loaded into the output register.
// Synchronous active-high reset clears configuration to defaults and all loop state to zero.

module bellows_drive_pi_controller (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration write port
  input  logic                                 cfg_we,
  input  logic [bdpi_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bdpi_pkg::CFG_DATA_W-1:0]      cfg_data,
  // input item stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [15:0] position, [22:16] pressure_mbar, [23] zero
  input  logic [bdpi_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // [2:0] op
  input  logic [bdpi_pkg::OP_W-1:0]            s_axis_tuser,
  // result item stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [7:0] duty_cycle, [24:8] velocity, [45:25] flow_estimate,
  // [66:46] filtered_flow, [67] stop_inhale, [71:68] zero
  output logic [bdpi_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
  import bdpi_pkg::*;

  typedef enum logic [20:0] {
    S_IDLE   = 21'h000001,
    S_START  = 21'h000002,
    S_V_VEL  = 21'h000004,
    S_V_SAT  = 21'h000008,
    S_V_FLW  = 21'h000010,
    S_V_FNEW = 21'h000020,
    S_V_FACC = 21'h000040,
    S_V_FFLT = 21'h000080,
    S_V_DIV  = 21'h000100,
    S_V_TGT  = 21'h000200,
    S_V_TDIV = 21'h000400,
    S_V_TVEL = 21'h000800,
    S_P_ERR  = 21'h001000,
    S_E_VEL  = 21'h002000,
    S_E_SAT  = 21'h004000,
    S_E_ERR  = 21'h008000,
    S_D_INT  = 21'h010000,
    S_D_P    = 21'h020000,
    S_D_I    = 21'h040000,
    S_D_CL   = 21'h080000,
    S_OUT    = 21'h100000
  } state_t;

  // divide by 65536 truncating toward zero
  function automatic logic signed [31:0] trunc16(input logic signed [ACC_W-1:0] a);
    logic signed [31:0] q;
    q = a[47:16];
    if (a[ACC_W-1] && (a[15:0] != 16'd0)) begin
      q = q + 32'sd1;
    end
    return q;
  endfunction

  state_t state;

  // configuration registers
  logic signed [15:0] bag_contact_position;
  logic signed [15:0] close_stop_position;
  logic [14:0]        mean_flow_target;
  logic [11:0]        exhale_velocity_target;
  logic [9:0]         inhale_periods;
  logic [6:0]         pressure_limit;

  // loop state
  logic signed [15:0] previous_position;
  logic [15:0]        step_count;
  logic signed [31:0] error_integral;
  logic [7:0]         duty_register;
  logic signed [20:0] flow_filter;

  // captured item and working registers
  logic [OP_W-1:0]     op;
  logic signed [15:0]  position;
  logic [6:0]          pressure_mbar;
  logic signed [16:0]  velocity;
  logic signed [20:0]  flow_estimate;
  logic                stop_inhale;
  logic signed [17:0]  err;
  logic [RAMP_W-1:0]   ramp_factor;
  logic                near_prev;
  logic                near_pos;
  logic                ramp;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] prod;

  // shared multiplier operands
  logic signed [MUL_A_W-1:0]         mul_a;
  logic signed [MUL_B_W-1:0]         mul_b;
  logic signed [MUL_A_W+MUL_B_W-1:0] mul_full;

  logic signed [16:0] diff_back;
  logic signed [16:0] diff_fwd;
  logic signed [16:0] bag_prev;
  logic signed [16:0] bag_pos;
  logic signed [16:0] vel_sat;
  logic signed [32:0] int_sum;
  logic signed [31:0] int_sat;
  logic signed [31:0] duty_raw;
  logic [7:0]         clamp_lo;
  logic [7:0]         clamp_hi;
  logic [7:0]         duty_clamped;
  logic signed [MUL_B_W-1:0] kp;
  logic signed [MUL_B_W-1:0] ki;
  logic [12:0]        target_vel;
  logic               in_accept;
  logic               out_load;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  assign s_axis_tready = (state == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state == S_OUT) && (!m_axis_tvalid || m_axis_tready);

  // position differences and branch conditions
  always_comb begin
    diff_back = {previous_position[15], previous_position} - {position[15], position};
    diff_fwd  = {position[15], position} - {previous_position[15], previous_position};
    bag_prev  = {bag_contact_position[15], bag_contact_position}
              - {previous_position[15], previous_position};
    bag_pos   = {bag_contact_position[15], bag_contact_position} - {position[15], position};
  end

  // saturate the scaled position step to the velocity range
  always_comb begin
    if (prod > 48'sd65535) begin
      vel_sat = 17'sd65535;
    end else if (prod < -48'sd65535) begin
      vel_sat = -17'sd65535;
    end else begin
      vel_sat = prod[16:0];
    end
  end

  // saturating integral update
  always_comb begin
    int_sum = {error_integral[31], error_integral} + {{15{err[17]}}, err};
    case (int_sum[32:31])
      2'b01:   int_sat = 32'sh7FFF_FFFF;
      2'b10:   int_sat = 32'sh8000_0000;
      default: int_sat = int_sum[31:0];
    endcase
  end

  // gains and duty limits of the active law
  always_comb begin
    kp       = K_SMALL;
    ki       = K_SMALL;
    clamp_lo = DUTY_MIN;
    clamp_hi = DUTY_MAX;
    case (op)
      OP_TICK_PRS: begin
        kp = KP_PRS;
        ki = KI_PRS;
      end
      OP_TICK_EXH: begin
        kp       = err[17] ? K_SMALL : KP_EXH;
        ki       = KI_EXH;
        clamp_lo = DUTY_EXH_MIN;
        clamp_hi = DUTY_EXH_MAX;
      end
      default: begin
        kp = err[17] ? K_SMALL : KP_INH;
      end
    endcase
  end

  // final duty: truncate, then clamp
  always_comb begin
    duty_raw = trunc16(acc);
    if (duty_raw < $signed({24'd0, clamp_lo})) begin
      duty_clamped = clamp_lo;
    end else if (duty_raw > $signed({24'd0, clamp_hi})) begin
      duty_clamped = clamp_hi;
    end else begin
      duty_clamped = duty_raw[7:0];
    end
  end

  assign target_vel = prod[31:19];

  // select multiplier operands per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_V_VEL: begin
        mul_a = {{15{diff_back[16]}}, diff_back};
        mul_b = MUL_B_W'(PERIODS_PER_SECOND);
      end
      S_E_VEL: begin
        mul_a = {{15{diff_fwd[16]}}, diff_fwd};
        mul_b = MUL_B_W'(PERIODS_PER_SECOND);
      end
      S_V_SAT: begin
        mul_a = {{11{flow_filter[20]}}, flow_filter};
        mul_b = FILT_OLD;
      end
      S_V_FLW: begin
        mul_a = {{15{velocity[16]}}, velocity};
        mul_b = near_prev ? FLOW_K_NEAR : FLOW_K_FAR;
      end
      S_V_FNEW: begin
        mul_a = prod[31:0];
        mul_b = FILT_NEW;
      end
      S_V_FACC: begin
        mul_a = {16'd0, step_count};
        mul_b = RAMP_SLOPE2;
      end
      S_V_TGT: begin
        mul_a = {17'd0, mean_flow_target};
        mul_b = {2'b00, ramp_factor};
      end
      S_V_TDIV: begin
        mul_a = {16'd0, prod[31:16]};
        mul_b = near_pos ? RECIP_8 : RECIP_12;
      end
      S_D_INT: begin
        mul_a = {{14{err[17]}}, err};
        mul_b = kp;
      end
      S_D_P: begin
        mul_a = error_integral;
        mul_b = ki;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  // ramp numerator over inhale periods
  assign div_req.start    = (state == S_V_FFLT) && ramp;
  assign div_req.dividend = prod[DIV_DVD_W-1:0];
  assign div_req.divisor  = inhale_periods;

  bdpi_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      bag_contact_position   <= '0;
      close_stop_position    <= '0;
      mean_flow_target       <= '0;
      exhale_velocity_target <= '0;
      inhale_periods         <= 10'd20;
      pressure_limit         <= 7'd20;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BAG_CONTACT: bag_contact_position   <= cfg_data;
        REG_CLOSE_STOP:  close_stop_position    <= cfg_data;
        REG_MEAN_FLOW:   mean_flow_target       <= cfg_data[14:0];
        REG_EXH_VEL:     exhale_velocity_target <= cfg_data[11:0];
        REG_INH_PERIODS: inhale_periods         <= cfg_data[9:0];
        REG_PRS_LIMIT:   pressure_limit         <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // sequencer and loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      previous_position <= '0;
      step_count        <= '0;
      error_integral    <= '0;
      duty_register     <= '0;
      flow_filter       <= '0;
      m_axis_tvalid     <= 1'b0;
    end else begin
      if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            case (s_axis_tuser)
              OP_START_VOL, OP_START_PRS, OP_START_EXH: state <= S_START;
              OP_TICK_VOL: state <= S_V_VEL;
              OP_TICK_PRS: state <= S_P_ERR;
              OP_TICK_EXH: state <= S_E_VEL;
              default:     state <= S_OUT;
            endcase
          end
        end
        S_START: begin
          previous_position <= position;
          step_count        <= '0;
          error_integral    <= '0;
          case (op)
            OP_START_VOL: duty_register <= DUTY_START_VOL;
            OP_START_PRS: duty_register <= DUTY_START_PRS;
            default:      duty_register <= DUTY_START_EXH;
          endcase
          state <= S_OUT;
        end
        S_V_VEL:  state <= S_V_SAT;
        S_V_SAT:  state <= S_V_FLW;
        S_V_FLW:  state <= S_V_FNEW;
        S_V_FNEW: state <= S_V_FACC;
        S_V_FACC: state <= S_V_FFLT;
        S_V_FFLT: begin
          flow_filter <= trunc16(acc)[20:0];
          state       <= ramp ? S_V_DIV : S_V_TGT;
        end
        S_V_DIV: begin
          if (div_rsp.done) begin
            state <= S_V_TGT;
          end
        end
        S_V_TGT:  state <= S_V_TDIV;
        S_V_TDIV: state <= S_V_TVEL;
        S_V_TVEL: state <= S_D_INT;
        S_P_ERR:  state <= S_D_INT;
        S_E_VEL:  state <= S_E_SAT;
        S_E_SAT:  state <= S_E_ERR;
        S_E_ERR:  state <= S_D_INT;
        S_D_INT: begin
          // pressure law drops the integral over its first four ticks
          if ((op == OP_TICK_PRS) && (step_count < 16'd4)) begin
            error_integral <= '0;
          end else begin
            error_integral <= int_sat;
          end
          state <= S_D_P;
        end
        S_D_P: state <= S_D_I;
        S_D_I: state <= S_D_CL;
        S_D_CL: begin
          duty_register     <= duty_clamped;
          previous_position <= position;
          if ((op != OP_TICK_EXH) && (step_count != 16'hFFFF)) begin
            step_count <= step_count + 16'd1;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_full[ACC_W-1:0];
    if (in_accept) begin
      op            <= s_axis_tuser;
      position      <= s_axis_tdata[15:0];
      pressure_mbar <= s_axis_tdata[22:16];
      velocity      <= '0;
      flow_estimate <= '0;
      stop_inhale   <= 1'b0;
    end
    case (state)
      S_V_VEL: begin
        near_prev <= (bag_prev < 17'sd60);
        near_pos  <= (bag_pos < 17'sd60);
        ramp      <= (step_count < {7'd0, inhale_periods[9:1]});
      end
      S_V_SAT, S_E_SAT: velocity <= vel_sat;
      S_V_FLW: acc <= prod;
      S_V_FNEW: flow_estimate <= prod[20:0];
      S_V_FACC: acc <= acc + prod;
      S_V_FFLT: ramp_factor <= FLOW_HIGH;
      S_V_DIV: begin
        if (div_rsp.done) begin
          ramp_factor <= div_rsp.quotient[RAMP_W-1:0] + RAMP_BASE;
        end
      end
      S_V_TVEL: err <= {5'd0, target_vel} - {velocity[16], velocity};
      S_P_ERR: begin
        err         <= {11'd0, pressure_limit} - {11'd0, pressure_mbar};
        stop_inhale <= (position < close_stop_position);
      end
      S_E_ERR: err <= {6'd0, exhale_velocity_target} - {velocity[16], velocity};
      S_D_P: acc <= $signed({24'd0, duty_register, 16'd0}) + prod;
      S_D_I: acc <= acc + prod;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {4'd0, stop_inhale, flow_filter, flow_estimate, velocity, duty_register};
    end
  end

endmodule
